// ----- rtl/multi_stack_leftmost_push_rightmost_pop_core_macros.svh -----
// Assertion macros for the plate stack core.
`ifndef MULTI_STACK_LEFTMOST_PUSH_RIGHTMOST_POP_CORE_MACROS_SVH
`define MULTI_STACK_LEFTMOST_PUSH_RIGHTMOST_POP_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MSTK_ASSERT_SAME(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MSTK_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- rtl/mstk_pkg.sv -----
// Shared constants and types for the plate stack core.
package mstk_pkg;

	localparam int NUM_STACKS_DEF  = 16;
	localparam int MAX_DEPTH_DEF   = 16;
	localparam int VALUE_WIDTH_DEF = 16;

	localparam int OP_W  = 2;
	localparam int VAL_W = 16;
	localparam int IDX_W = 4;
	localparam int ST_W  = 2;
	localparam int CAP_W = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
	localparam logic [OP_W-1:0] OP_POP    = 2'd1;
	localparam logic [OP_W-1:0] OP_POP_AT = 2'd2;

	localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	localparam logic [1:0] KIND_NOP    = 2'd0;
	localparam logic [1:0] KIND_PUSH   = 2'd1;
	localparam logic [1:0] KIND_POP    = 2'd2;
	localparam logic [1:0] KIND_POP_AT = 2'd3;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [1:0]       kind;
		logic [IDX_W-1:0] idx;
		logic             idx_ok;
	} cmd_ctl_t;

endpackage

// ----- rtl/mstk_if.sv -----
// Command and response channel interfaces.
interface mstk_cmd_if;
	import mstk_pkg::*;

	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  operation;
	logic [VAL_W-1:0] value;
	logic [IDX_W-1:0] stack_index;

	modport source (output valid, output operation, output value, output stack_index,
		input ready);
	modport sink (input valid, input operation, input value, input stack_index,
		output ready);
endinterface

interface mstk_rsp_if;
	import mstk_pkg::*;

	logic             valid;
	logic             ready;
	logic [ST_W-1:0]  status;
	logic [VAL_W-1:0] popped_value;

	modport source (output valid, output status, output popped_value, input ready);
	modport sink (input valid, input status, input popped_value, output ready);
endinterface

// ----- rtl/mstk_front.sv -----
// Front end: takes commands and classifies them for the back end.
module mstk_front #(
	parameter int NUM_STACKS  = mstk_pkg::NUM_STACKS_DEF,
	parameter int VALUE_WIDTH = mstk_pkg::VALUE_WIDTH_DEF
) (
	mstk_cmd_if.sink             cmd,
	output logic                 q_valid,
	input  logic                 q_ready,
	output mstk_pkg::cmd_ctl_t   q_ctl,
	output logic [VALUE_WIDTH-1:0] q_value
);
	import mstk_pkg::*;

	// 9 bits hold any stack count up to 256
	localparam int IXW  = (IDX_W > 9) ? IDX_W : 9;
	localparam int MAXW = (VALUE_WIDTH > VAL_W) ? VALUE_WIDTH : VAL_W;

	logic [MAXW-1:0] value_ext;

	assign value_ext = MAXW'(cmd.value);
	assign q_value   = value_ext[VALUE_WIDTH-1:0];
	assign q_valid   = cmd.valid;
	assign cmd.ready = q_ready;

	always_comb begin
		case (cmd.operation)
			OP_PUSH:   q_ctl.kind = KIND_PUSH;
			OP_POP:    q_ctl.kind = KIND_POP;
			OP_POP_AT: q_ctl.kind = KIND_POP_AT;
			default:   q_ctl.kind = KIND_NOP;
		endcase
		q_ctl.idx    = cmd.stack_index;
		q_ctl.idx_ok = IXW'(cmd.stack_index) < IXW'(NUM_STACKS);
	end

endmodule

// ----- rtl/mstk_queue.sv -----
// Short command queue between front and back end.
module mstk_queue #(
	parameter int WIDTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);
	import mstk_pkg::*;

	localparam int PW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  cnt_q;
	logic             push;
	logic             pop;

	assign in_ready  = cnt_q != CNTW'(QUEUE_DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_data  = entry_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/mstk_back.sv -----
// Back end: picks the stack, updates fill counts and plate memory, holds the result.
`include "multi_stack_leftmost_push_rightmost_pop_core_macros.svh"

module mstk_back #(
	parameter int NUM_STACKS  = mstk_pkg::NUM_STACKS_DEF,
	parameter int MAX_DEPTH   = mstk_pkg::MAX_DEPTH_DEF,
	parameter int VALUE_WIDTH = mstk_pkg::VALUE_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [mstk_pkg::CAP_W-1:0]  capacity,
	input  logic                        q_valid,
	output logic                        q_ready,
	input  mstk_pkg::cmd_ctl_t          q_ctl,
	input  logic [VALUE_WIDTH-1:0]      q_value,
	mstk_rsp_if.source                  rsp
);
	import mstk_pkg::*;

	localparam int SW        = $clog2(NUM_STACKS);
	localparam int DW        = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int CW        = $clog2(MAX_DEPTH + 1);
	localparam int EW        = (CW > CAP_W) ? CW : CAP_W;
	localparam int IXW       = (SW > IDX_W) ? SW : IDX_W;
	localparam int AW        = SW + DW;
	localparam int MEM_DEPTH = NUM_STACKS * (2 ** DW);
	localparam int MAXW      = (VALUE_WIDTH > VAL_W) ? VALUE_WIDTH : VAL_W;

	logic [CW-1:0]          fill_q [NUM_STACKS];
	logic [VALUE_WIDTH-1:0] plate_q [MEM_DEPTH];

	logic                   valid_s2;
	logic [ST_W-1:0]        status_s2;
	logic                   hit_s2;
	logic [VALUE_WIDTH-1:0] rd_s2;

	logic [NUM_STACKS-1:0]  nonfull;
	logic [NUM_STACKS-1:0]  nonempty;
	logic                   any_nonfull;
	logic                   any_nonempty;
	logic [SW-1:0]          left_idx;
	logic [SW-1:0]          right_idx;
	logic [IXW-1:0]         idx_ext;
	logic [SW-1:0]          at_idx;
	logic [SW-1:0]          target;
	logic                   do_push;
	logic                   do_pop;
	logic [ST_W-1:0]        status;
	logic [CW-1:0]          tgt_fill;
	logic [CW-1:0]          fill_dec;
	logic [DW-1:0]          slot;
	logic [AW-1:0]          addr;
	logic                   advance;
	logic                   fire;
	logic [MAXW-1:0]        rd_ext;

	assign advance = !valid_s2 || rsp.ready;
	assign q_ready = advance;
	assign fire    = q_valid && advance;

	// not-full test: below capacity and below the maximum stack depth
	always_comb begin
		for (int k = 0; k < NUM_STACKS; k++) begin
			nonfull[k]  = (EW'(fill_q[k]) < EW'(capacity)) && (fill_q[k] != CW'(MAX_DEPTH));
			nonempty[k] = fill_q[k] != '0;
		end
	end

	assign any_nonfull  = |nonfull;
	assign any_nonempty = |nonempty;

	// leftmost not full, rightmost not empty
	always_comb begin
		left_idx  = '0;
		right_idx = '0;
		for (int k = NUM_STACKS - 1; k >= 0; k--) begin
			if (nonfull[k]) begin
				left_idx = SW'(k);
			end
		end
		for (int k = 0; k < NUM_STACKS; k++) begin
			if (nonempty[k]) begin
				right_idx = SW'(k);
			end
		end
	end

	assign idx_ext = IXW'(q_ctl.idx);
	assign at_idx  = idx_ext[SW-1:0];

	always_comb begin
		do_push = 1'b0;
		do_pop  = 1'b0;
		target  = left_idx;
		status  = ST_DONE;
		case (q_ctl.kind)
			KIND_PUSH: begin
				if (any_nonfull) begin
					do_push = 1'b1;
				end else begin
					status = ST_FULL;
				end
			end
			KIND_POP: begin
				target = right_idx;
				if (any_nonempty) begin
					do_pop = 1'b1;
				end else begin
					status = ST_EMPTY;
				end
			end
			KIND_POP_AT: begin
				target = at_idx;
				if (q_ctl.idx_ok && nonempty[at_idx]) begin
					do_pop = 1'b1;
				end else begin
					status = ST_EMPTY;
				end
			end
			default: begin
				status = ST_DONE;
			end
		endcase
	end

	assign tgt_fill = fill_q[target];
	assign fill_dec = tgt_fill - 1'b1;
	assign slot     = do_pop ? fill_dec[DW-1:0] : tgt_fill[DW-1:0];
	assign addr     = {target, slot};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_STACKS; k++) begin
				fill_q[k] <= '0;
			end
		end else if (fire && do_push) begin
			fill_q[target] <= tgt_fill + 1'b1;
		end else if (fire && do_pop) begin
			fill_q[target] <= fill_dec;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && do_push) begin
			plate_q[addr] <= q_value;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && do_pop) begin
			rd_s2 <= plate_q[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2  <= 1'b0;
			hit_s2    <= 1'b0;
			status_s2 <= ST_DONE;
		end else begin
			if (advance) begin
				valid_s2 <= q_valid;
			end
			if (fire) begin
				hit_s2    <= do_pop;
				status_s2 <= status;
			end
		end
	end

	assign rd_ext           = MAXW'(rd_s2);
	assign rsp.valid        = valid_s2;
	assign rsp.status       = status_s2;
	assign rsp.popped_value = hit_s2 ? rd_ext[VAL_W-1:0] : '0;

	`MSTK_ASSERT_SAME(a_hit_is_done, valid_s2 && hit_s2, status_s2 == ST_DONE, "pop data without done status")
	`MSTK_ASSERT_NEXT(a_stall_holds, valid_s2 && !rsp.ready, valid_s2 && $stable(status_s2) && $stable(hit_s2) && (!hit_s2 || $stable(rd_s2)), "stalled result changed")
	`MSTK_ASSERT_NEXT(a_pop_finds, fire && q_ctl.kind == KIND_POP && any_nonempty, valid_s2 && hit_s2, "pop missed a nonempty stack")

endmodule

// ----- rtl/multi_stack_leftmost_push_rightmost_pop_core.sv -----
// Top level of the plate stack core: front end, command queue, back end.
// A command passes through the queue entry and the result register before its result is offered.
// Throughput: one command per cycle unless stalled; at most one plate memory access per command.
// A stalled response holds the back end; the queue then fills and the front stops after two.
// Reset clears fill counts, queue and result register at once; plate memory is not cleared.
// Capacity resets to 16.
module multi_stack_leftmost_push_rightmost_pop_core #(
	parameter int NUM_STACKS  = mstk_pkg::NUM_STACKS_DEF,
	parameter int MAX_DEPTH   = mstk_pkg::MAX_DEPTH_DEF,
	parameter int VALUE_WIDTH = mstk_pkg::VALUE_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [mstk_pkg::CAP_W-1:0] cfg_wdata,
	mstk_cmd_if.sink                   cmd,
	mstk_rsp_if.source                 rsp
);
	import mstk_pkg::*;

	localparam int CTLW = $bits(cmd_ctl_t);
	localparam int QW   = CTLW + VALUE_WIDTH;

	logic [CAP_W-1:0]       capacity_q;
	logic                   fq_valid;
	logic                   fq_ready;
	cmd_ctl_t               f_ctl;
	logic [VALUE_WIDTH-1:0] f_value;
	logic                   bq_valid;
	logic                   bq_ready;
	logic [QW-1:0]          bq_data;
	cmd_ctl_t               b_ctl;
	logic [VALUE_WIDTH-1:0] b_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	mstk_front #(
		.NUM_STACKS  (NUM_STACKS),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_front (
		.cmd     (cmd),
		.q_valid (fq_valid),
		.q_ready (fq_ready),
		.q_ctl   (f_ctl),
		.q_value (f_value)
	);

	mstk_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_data   ({f_ctl, f_value}),
		.out_valid (bq_valid),
		.out_ready (bq_ready),
		.out_data  (bq_data)
	);

	assign b_ctl   = bq_data[QW-1:VALUE_WIDTH];
	assign b_value = bq_data[VALUE_WIDTH-1:0];

	mstk_back #(
		.NUM_STACKS  (NUM_STACKS),
		.MAX_DEPTH   (MAX_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.capacity (capacity_q),
		.q_valid  (bq_valid),
		.q_ready  (bq_ready),
		.q_ctl    (b_ctl),
		.q_value  (b_value),
		.rsp      (rsp)
	);

endmodule

// ----- bench/mstk_plate_checker.sv -----
// Plate stack checker: watches command, response and capacity writes, predicts and compares.
`timescale 1ns / 100ps

module mstk_plate_checker #(
	parameter int NUM_STACKS = mstk_pkg::NUM_STACKS_DEF,
	parameter int MAX_DEPTH  = mstk_pkg::MAX_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [mstk_pkg::CAP_W-1:0] cfg_wdata,
	mstk_cmd_if                        cmd,
	mstk_rsp_if                        rsp,
	output int                         fail_count,
	output int                         pending
);
	import mstk_pkg::*;

	typedef struct {
		logic [ST_W-1:0]  status;
		logic [VAL_W-1:0] popped;
	} plate_result_t;

	logic [VAL_W-1:0] plate_mem [NUM_STACKS][MAX_DEPTH];
	int               fill_cnt [NUM_STACKS];
	logic [CAP_W-1:0] capacity_q = CAP_RESET;
	plate_result_t    result_q [$];
	int               errors = 0;

	function automatic logic [VAL_W-1:0] take_plate(input int k);
		fill_cnt[k]--;
		return plate_mem[k][fill_cnt[k]];
	endfunction

	function automatic plate_result_t apply_op(input logic [OP_W-1:0] op,
		input logic [VAL_W-1:0] val, input logic [IDX_W-1:0] idx);
		plate_result_t r;
		int            lim;
		bit            found;
		r.status = ST_DONE;
		r.popped = '0;
		found = 1'b0;
		// capacity above the stack depth saturates
		lim = (capacity_q > MAX_DEPTH) ? MAX_DEPTH : int'(capacity_q);
		case (op)
			OP_PUSH: begin
				for (int k = 0; k < NUM_STACKS && !found; k++) begin
					if (fill_cnt[k] < lim) begin
						plate_mem[k][fill_cnt[k]] = val;
						fill_cnt[k]++;
						found = 1'b1;
					end
				end
				if (!found)
					r.status = ST_FULL;
			end
			OP_POP: begin
				for (int k = NUM_STACKS - 1; k >= 0 && !found; k--) begin
					if (fill_cnt[k] != 0) begin
						r.popped = take_plate(k);
						found = 1'b1;
					end
				end
				if (!found)
					r.status = ST_EMPTY;
			end
			OP_POP_AT: begin
				if (idx < NUM_STACKS && fill_cnt[idx] != 0)
					r.popped = take_plate(idx);
				else
					r.status = ST_EMPTY;
			end
			default: ; // unused code: no change, done status
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		plate_result_t want;
		if (!arst_n) begin
			foreach (fill_cnt[k])
				fill_cnt[k] = 0;
			capacity_q = CAP_RESET;
			result_q.delete();
			pending <= 0;
			fail_count <= errors;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (result_q.size() == 0) begin
					$display("%0t: response transfer with nothing expected (status %0d value %0h)",
						$time, rsp.status, rsp.popped_value);
					errors++;
				end else begin
					want = result_q.pop_front();
					if (rsp.status !== want.status) begin
						$display("%0t: status mismatch, expected %0d actual %0d",
							$time, want.status, rsp.status);
						errors++;
					end
					if (rsp.popped_value !== want.popped) begin
						$display("%0t: popped_value mismatch, expected %0h actual %0h",
							$time, want.popped, rsp.popped_value);
						errors++;
					end
				end
			end
			if (cmd.valid && cmd.ready)
				result_q.insert(result_q.size(),
					apply_op(cmd.operation, cmd.value, cmd.stack_index));
			if (cfg_we)
				capacity_q = cfg_wdata;
			pending <= result_q.size();
			fail_count <= errors;
		end
	end

endmodule

// ----- bench/multi_stack_leftmost_push_rightmost_pop_core_tb.sv -----
// Testbench top for the plate stack core: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module multi_stack_leftmost_push_rightmost_pop_core_tb;
	import mstk_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 3000;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 90;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_wdata;
	int               fail_count;
	int               pending;
	int               send_idle = 26;
	int               recv_idle = 87;

	mstk_cmd_if cmd ();
	mstk_rsp_if rsp ();

	multi_stack_leftmost_push_rightmost_pop_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.rsp       (rsp)
	);

	mstk_plate_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.cmd        (cmd),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// response side back-pressure
	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// ends the run when no transfer happens for too long
	initial begin : stall_watch
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
		$display("FAIL multi_stack_leftmost_push_rightmost_pop_core");
		$finish;
	end

	task automatic send_cmd(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val,
		input logic [IDX_W-1:0] idx);
		while ($urandom_range(99) < send_idle) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.operation <= op;
		cmd.value <= val;
		cmd.stack_index <= idx;
		do
			@(posedge clk);
		while (!cmd.ready);
	endtask

	// capacity changes only once every result is back
	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		cmd.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		cfg_we <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		int               phase_cap [PHASES];
		int               push_pct [PHASES];
		int               r;
		logic [OP_W-1:0]  op;
		logic [VAL_W-1:0] val;
		logic [IDX_W-1:0] idx;

		phase_cap = '{31, 1, 2, 16, 0, 0};
		push_pct = '{70, 75, 70, 40, 30, 60};
		phase_cap[PHASES - 1] = $urandom_range(31, 1);

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		cmd.valid <= 1'b0;
		cmd.operation <= OP_PUSH;
		cmd.value <= '0;
		cmd.stack_index <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pops, unused code, extreme values at reset capacity
		send_cmd(OP_POP, 16'h0000, 4'd0);
		send_cmd(OP_POP_AT, 16'h0000, 4'd15);
		send_cmd(OP_UNUSED, 16'hFFFF, 4'd15);
		send_cmd(OP_PUSH, 16'hFFFF, 4'd0);
		send_cmd(OP_PUSH, 16'h0000, 4'd0);
		send_cmd(OP_PUSH, 16'h1234, 4'd15);
		// capacity below the fill of stack 0: it counts as full
		write_capacity(5'd1);
		send_cmd(OP_PUSH, 16'hA5A5, 4'd0);
		send_cmd(OP_POP, 16'hFFFF, 4'd0);
		send_cmd(OP_POP_AT, 16'h0000, 4'd0);
		// zero capacity rejects every push, pops still drain
		write_capacity(5'd0);
		send_cmd(OP_PUSH, 16'h5A5A, 4'd0);
		send_cmd(OP_POP, 16'h0000, 4'd0);
		send_cmd(OP_POP_AT, 16'h0000, 4'd0);
		send_cmd(OP_POP_AT, 16'h0000, 4'd0);

		for (int p = 0; p < PHASES; p++) begin
			if (p == 2) begin
				send_idle = 87;
				recv_idle = 26;
			end else if (p == 4) begin
				send_idle = 0;
				recv_idle = 0;
			end
			write_capacity(CAP_W'(phase_cap[p]));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(99);
				if (r < 5)
					op = OP_UNUSED;
				else if (r < 5 + push_pct[p])
					op = OP_PUSH;
				else if (r[0])
					op = OP_POP;
				else
					op = OP_POP_AT;
				r = $urandom_range(9);
				val = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : VAL_W'($urandom);
				// low stacks fill first, so aim there half the time
				idx = $urandom_range(1) ? IDX_W'($urandom_range(3)) : IDX_W'($urandom_range(15));
				send_cmd(op, val, idx);
			end
		end

		cmd.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("PASS multi_stack_leftmost_push_rightmost_pop_core");
		else
			$display("FAIL multi_stack_leftmost_push_rightmost_pop_core");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/mstk_pkg.sv
rtl/mstk_if.sv
rtl/mstk_front.sv
rtl/mstk_queue.sv
rtl/mstk_back.sv
rtl/multi_stack_leftmost_push_rightmost_pop_core.sv
bench/mstk_plate_checker.sv
bench/multi_stack_leftmost_push_rightmost_pop_core_tb.sv
